[rtl/ihg_pkg.sv]
// shared types and constants of the herded gibbs pixel updater
`default_nettype none
package ihg_pkg;
    localparam int OPCODE_W = 3;
    localparam int COORD_W  = 6;
    localparam int SLOT_W   = 5;
    localparam int VALUE_W  = 17;
    localparam int SWEEP_W  = 16;
    localparam int UPCNT_W  = 16;
    localparam int ERR_W    = 2;

    localparam logic [OPCODE_W-1:0] OP_LOAD_PIXEL  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_WEIGHT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_PROB   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_UPDATE      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_EVALUATE    = 3'd4;

    localparam int SLOTS_PER_PIX = 16;
    localparam int SLOT_IDX_W    = 4;
    localparam int PROB_ENTRIES  = 18;

    localparam logic REG_HERD_MODE     = 1'b0;
    localparam logic REG_ESTIMATE_MODE = 1'b1;
    localparam int   CFG_W             = 2;

    localparam logic [1:0] HM_FULL_CONFIG = 2'd0;
    localparam logic [1:0] HM_COUNT_SHARE = 2'd1;
    localparam logic [1:0] HM_SINGLE      = 2'd2;
    localparam logic [1:0] HM_RANDOM      = 2'd3;

    localparam logic EM_MEAN = 1'b0;
    localparam logic EM_LAST = 1'b1;

    localparam logic [ERR_W-1:0] ERR_RIGHT = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TIE   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_WRONG = 2'd2;
endpackage
`default_nettype wire

[rtl/ihg_if.sv]
// item and result channel interfaces
`default_nettype none
interface ihg_item_if;
    logic                          valid;
    logic                          ready;
    logic [ihg_pkg::OPCODE_W-1:0]  opcode;
    logic [ihg_pkg::COORD_W-1:0]   col;
    logic [ihg_pkg::COORD_W-1:0]   row;
    logic                          given_bit;
    logic [ihg_pkg::SLOT_W-1:0]    slot;
    logic [ihg_pkg::VALUE_W-1:0]   sample_value;
    logic [ihg_pkg::SWEEP_W-1:0]   sweeps_done;
    modport source (output valid, opcode, col, row, given_bit, slot, sample_value,
                    sweeps_done, input ready);
    modport sink (input valid, opcode, col, row, given_bit, slot, sample_value,
                  sweeps_done, output ready);
endinterface

interface ihg_result_if;
    logic                         valid;
    logic                         ready;
    logic                         spin_out;
    logic [ihg_pkg::UPCNT_W-1:0]  up_count;
    logic [ihg_pkg::ERR_W-1:0]    error_halves;
    modport source (output valid, spin_out, up_count, error_halves, input ready);
    modport sink (input valid, spin_out, up_count, error_halves, output ready);
endinterface
`default_nettype wire

[rtl/ihg_pix_ram.sv]
// per-pixel store: observed bit, spin and up-count, one read and one write port
`default_nettype none
module ihg_pix_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 18
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/ihg_wgt_ram.sv]
// herding weight store, sixteen slots per pixel
`default_nettype none
module ihg_wgt_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 17
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/ising_pixel_herded_gibbs_update.sv]
// herded gibbs pixel updater: sequencer, datapath and stores
// an update goes from accept to the result register through own pixel read,
// four neighbour reads from the single pixel port, table lookup and weight rmw
// other items go through own pixel read, execute and the result register
// one item at a time; the next item is taken once the previous one reaches
// the output register, which holds it until the sink takes it
// reset clears the sequencer and output valid and sets the mode registers to random herding and mean estimate only
`default_nettype none
module ising_pixel_herded_gibbs_update #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64,
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    ihg_item_if.sink                       item_in,
    ihg_result_if.source                   result_out,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [ihg_pkg::CFG_W-1:0] cfg_data
);
    localparam int PIX_N = IMG_WIDTH * IMG_HEIGHT;
    localparam int PW    = $clog2(PIX_N);
    localparam int CW    = COUNT_BITS;
    localparam int WB    = FRAC_BITS + 1;
    localparam int VW    = (WB > ihg_pkg::VALUE_W) ? WB : ihg_pkg::VALUE_W;
    localparam int EW    = CW + ihg_pkg::SWEEP_W + 1;
    localparam int WAW   = PW + ihg_pkg::SLOT_IDX_W;

    localparam logic [VW:0]   FX_ONE  = (VW+1)'(1) << FRAC_BITS;
    localparam logic [VW:0]   W_MAX   = (FX_ONE << 1) - (VW+1)'(1);
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OWN  = 3'd1;
    localparam logic [2:0] S_NB   = 3'd2;
    localparam logic [2:0] S_PROB = 3'd3;
    localparam logic [2:0] S_WRD  = 3'd4;
    localparam logic [2:0] S_EXEC = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] herd_mode_reg, herd_mode_next;
    logic       est_mode_reg, est_mode_next;

    logic [ihg_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic                         bit_reg, bit_next;
    logic [ihg_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [ihg_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic [ihg_pkg::SWEEP_W-1:0]  sweeps_reg, sweeps_next;
    logic                         inr_reg, inr_next;
    logic [3:0]                   pm_reg, pm_next;
    logic [PW-1:0]                pix_reg, pix_next;
    logic                         own_obs_reg, own_obs_next;
    logic                         own_spin_reg, own_spin_next;
    logic [CW-1:0]                own_cnt_reg, own_cnt_next;
    logic [3:0]                   nb_reg, nb_next;
    logic [VW-1:0]                p_reg, p_next;
    logic [3:0]                   sl_reg, sl_next;
    logic                         res_spin_reg, res_spin_next;
    logic [ihg_pkg::UPCNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [ihg_pkg::ERR_W-1:0]    res_err_reg, res_err_next;
    logic                         out_spin_reg, out_spin_next;
    logic [ihg_pkg::UPCNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [ihg_pkg::ERR_W-1:0]    out_err_reg, out_err_next;

    logic [ihg_pkg::VALUE_W-1:0] prob_reg [ihg_pkg::PROB_ENTRIES];

    logic          accept;
    logic [PW-1:0] pix_calc;
    logic          inr_calc;
    logic [3:0]    pm_calc;
    logic [PW-1:0] nb_addr [4];

    logic          pix_we;
    logic [PW-1:0] pix_waddr, pix_raddr;
    logic [CW+1:0] pix_wdata, pix_rdata;
    logic          wgt_we;
    logic [WAW-1:0] wgt_waddr, wgt_raddr;
    logic [WB-1:0] wgt_wdata, wgt_rdata;

    logic [2:0]    up_n, pres_n, pos;
    logic [3:0]    pattern;
    logic [4:0]    pidx;
    logic [VW:0]   entry;
    logic [3:0]    sl_calc;
    logic [VW:0]   w_sum, w_new;
    logic          upd_spin;
    logic [CW-1:0] cnt_new;
    logic [EW-1:0] twice, sweeps_x;
    logic [ihg_pkg::ERR_W-1:0] err_calc;

    assign accept         = item_in.valid && item_in.ready;
    assign item_in.ready  = (state_reg == S_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.spin_out     = out_spin_reg;
    assign result_out.up_count     = out_cnt_reg;
    assign result_out.error_halves = out_err_reg;

    assign inr_calc = (int'(item_in.col) < IMG_WIDTH) && (int'(item_in.row) < IMG_HEIGHT);
    assign pix_calc = PW'(PW'(item_in.row) * PW'(IMG_WIDTH) + PW'(item_in.col));
    assign pm_calc  = {(int'(item_in.row) + 1 < IMG_HEIGHT), (item_in.row != '0),
                       (int'(item_in.col) + 1 < IMG_WIDTH), (item_in.col != '0)};

    // absent neighbours read the pixel itself, their data is masked later
    always_comb
    begin
        nb_addr[0] = pm_reg[0] ? PW'(pix_reg - PW'(1)) : pix_reg;
        nb_addr[1] = pm_reg[1] ? PW'(pix_reg + PW'(1)) : pix_reg;
        nb_addr[2] = pm_reg[2] ? PW'(pix_reg - PW'(IMG_WIDTH)) : pix_reg;
        nb_addr[3] = pm_reg[3] ? PW'(pix_reg + PW'(IMG_WIDTH)) : pix_reg;
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  pix_raddr = pix_calc;
            S_OWN:   pix_raddr = nb_addr[0];
            S_NB:    pix_raddr = nb_addr[2'(k_reg + 2'd1)];
            default: pix_raddr = pix_reg;
        endcase
    end

    // neighbour field and table lookup
    always_comb
    begin
        up_n    = 3'($countones(nb_reg & pm_reg));
        pres_n  = 3'($countones(pm_reg));
        pattern = '0;
        pos     = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (pm_reg[i])
            begin
                pattern = pattern | (4'(nb_reg[i]) << pos);
                pos     = 3'(pos + 3'd1);
            end
        end
        pidx  = 5'((own_obs_reg ? 5'd9 : 5'd0) + {1'b0, up_n, 1'b0} + 5'd4 - {2'b0, pres_n});
        entry = (VW+1)'(prob_reg[pidx]);
        case (herd_mode_reg)
            ihg_pkg::HM_FULL_CONFIG: sl_calc = pattern;
            ihg_pkg::HM_COUNT_SHARE: sl_calc = {1'b0, up_n};
            default:                 sl_calc = '0;
        endcase
    end

    assign wgt_raddr = {pix_reg, sl_calc};

    // herding step and count
    always_comb
    begin
        w_sum = (VW+1)'(wgt_rdata) + (VW+1)'(p_reg);
        w_new = w_sum;
        if (herd_mode_reg == ihg_pkg::HM_RANDOM)
        begin
            upd_spin = ((VW+1)'(val_reg) < (VW+1)'(p_reg));
        end
        else
        begin
            upd_spin = (w_sum >= FX_ONE);
            if (upd_spin)
            begin
                w_new = w_sum - FX_ONE;
            end
        end
        if (w_new > W_MAX)
        begin
            w_new = W_MAX;
        end
        cnt_new = (upd_spin && (own_cnt_reg != CNT_MAX)) ? CW'(own_cnt_reg + CW'(1))
                                                         : own_cnt_reg;
    end

    // evaluation against the true bit
    always_comb
    begin
        twice    = EW'({own_cnt_reg, 1'b0});
        sweeps_x = EW'(sweeps_reg);
        if (est_mode_reg == ihg_pkg::EM_MEAN)
        begin
            if (twice < sweeps_x)
                err_calc = bit_reg ? ihg_pkg::ERR_WRONG : ihg_pkg::ERR_RIGHT;
            else if (twice == sweeps_x)
                err_calc = ihg_pkg::ERR_TIE;
            else
                err_calc = bit_reg ? ihg_pkg::ERR_RIGHT : ihg_pkg::ERR_WRONG;
        end
        else
        begin
            if (own_spin_reg)
                err_calc = bit_reg ? ihg_pkg::ERR_RIGHT : ihg_pkg::ERR_WRONG;
            else
                err_calc = bit_reg ? ihg_pkg::ERR_WRONG : ihg_pkg::ERR_RIGHT;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        herd_mode_next = herd_mode_reg;
        est_mode_next  = est_mode_reg;
        op_next        = op_reg;
        bit_next       = bit_reg;
        slot_next      = slot_reg;
        val_next       = val_reg;
        sweeps_next    = sweeps_reg;
        inr_next       = inr_reg;
        pm_next        = pm_reg;
        pix_next       = pix_reg;
        own_obs_next   = own_obs_reg;
        own_spin_next  = own_spin_reg;
        own_cnt_next   = own_cnt_reg;
        nb_next        = nb_reg;
        p_next         = p_reg;
        sl_next        = sl_reg;
        res_spin_next  = res_spin_reg;
        res_cnt_next   = res_cnt_reg;
        res_err_next   = res_err_reg;
        out_spin_next  = out_spin_reg;
        out_cnt_next   = out_cnt_reg;
        out_err_next   = out_err_reg;
        pix_we         = 1'b0;
        pix_waddr      = pix_reg;
        pix_wdata      = {own_obs_reg, own_spin_reg, own_cnt_reg};
        wgt_we         = 1'b0;
        wgt_waddr      = {pix_reg, sl_reg};
        wgt_wdata      = WB'(w_new);

        if (cfg_we)
        begin
            if (cfg_index == ihg_pkg::REG_HERD_MODE)
                herd_mode_next = cfg_data;
            else
                est_mode_next = cfg_data[0];
        end

        if (result_out.valid && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = item_in.opcode;
                    bit_next    = item_in.given_bit;
                    slot_next   = item_in.slot;
                    val_next    = item_in.sample_value;
                    sweeps_next = item_in.sweeps_done;
                    inr_next    = inr_calc;
                    pm_next     = pm_calc;
                    pix_next    = pix_calc;
                    state_next  = S_OWN;
                end
            end
            S_OWN:
            begin
                own_obs_next  = pix_rdata[CW+1];
                own_spin_next = pix_rdata[CW];
                own_cnt_next  = pix_rdata[CW-1:0];
                k_next        = '0;
                state_next    = (inr_reg && op_reg == ihg_pkg::OP_UPDATE) ? S_NB : S_EXEC;
            end
            S_NB:
            begin
                nb_next[k_reg] = pix_rdata[CW];
                k_next         = 2'(k_reg + 2'd1);
                if (k_reg == 2'd3)
                    state_next = S_PROB;
            end
            S_PROB:
            begin
                // an entry above one counts as one
                p_next     = VW'((entry > FX_ONE) ? FX_ONE : entry);
                sl_next    = sl_calc;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                wgt_we        = (herd_mode_reg != ihg_pkg::HM_RANDOM);
                pix_we        = 1'b1;
                pix_wdata     = {own_obs_reg, upd_spin, cnt_new};
                res_spin_next = upd_spin;
                res_cnt_next  = ihg_pkg::UPCNT_W'(cnt_new);
                res_err_next  = ihg_pkg::ERR_RIGHT;
                state_next    = S_DONE;
            end
            S_EXEC:
            begin
                res_spin_next = own_spin_reg;
                res_cnt_next  = ihg_pkg::UPCNT_W'(own_cnt_reg);
                res_err_next  = ihg_pkg::ERR_RIGHT;
                if (!inr_reg)
                begin
                    res_spin_next = 1'b0;
                    res_cnt_next  = '0;
                end
                else
                begin
                    case (op_reg)
                        ihg_pkg::OP_LOAD_PIXEL:
                        begin
                            pix_we        = 1'b1;
                            pix_wdata     = {bit_reg, bit_reg, CW'(0)};
                            res_spin_next = bit_reg;
                            res_cnt_next  = '0;
                        end
                        ihg_pkg::OP_LOAD_WEIGHT:
                        begin
                            wgt_we    = (int'(slot_reg) < ihg_pkg::SLOTS_PER_PIX);
                            wgt_waddr = {pix_reg, slot_reg[ihg_pkg::SLOT_IDX_W-1:0]};
                            wgt_wdata = WB'(VW'(val_reg));
                        end
                        ihg_pkg::OP_EVALUATE:
                        begin
                            res_err_next = err_calc;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_spin_next  = res_spin_reg;
                    out_cnt_next   = res_cnt_reg;
                    out_err_next   = res_err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            herd_mode_reg <= ihg_pkg::HM_RANDOM;
            est_mode_reg  <= ihg_pkg::EM_MEAN;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            herd_mode_reg <= herd_mode_next;
            est_mode_reg  <= est_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        bit_reg      <= bit_next;
        slot_reg     <= slot_next;
        val_reg      <= val_next;
        sweeps_reg   <= sweeps_next;
        inr_reg      <= inr_next;
        pm_reg       <= pm_next;
        pix_reg      <= pix_next;
        own_obs_reg  <= own_obs_next;
        own_spin_reg <= own_spin_next;
        own_cnt_reg  <= own_cnt_next;
        nb_reg       <= nb_next;
        p_reg        <= p_next;
        sl_reg       <= sl_next;
        res_spin_reg <= res_spin_next;
        res_cnt_reg  <= res_cnt_next;
        res_err_reg  <= res_err_next;
        out_spin_reg <= out_spin_next;
        out_cnt_reg  <= out_cnt_next;
        out_err_reg  <= out_err_next;
    end

    // probability table is written when the item is taken; it needs no pixel
    always_ff @(posedge clk)
    begin
        if (accept && item_in.opcode == ihg_pkg::OP_LOAD_PROB &&
            int'(item_in.slot) < ihg_pkg::PROB_ENTRIES)
        begin
            prob_reg[item_in.slot] <= item_in.sample_value;
        end
    end

    ihg_pix_ram #(
        .DEPTH (PIX_N),
        .AW    (PW),
        .DW    (CW + 2)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    ihg_wgt_ram #(
        .DEPTH (PIX_N * ihg_pkg::SLOTS_PER_PIX),
        .AW    (WAW),
        .DW    (WB)
    ) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wgt_wdata),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    a_accept_to_own: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_OWN))
        else $error("accepted item did not start with own pixel read");

    a_wgt_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wgt_we |-> (state_reg == S_WRD || state_reg == S_EXEC))
        else $error("weight write outside a write phase");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result appeared without finishing an item");

    a_pix_write_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
        pix_we |-> !item_in.ready)
        else $error("pixel write while taking a new item");
endmodule
`default_nettype wire
